@@ hw/rtl/olid_pkg.sv @@
// shared codes and cell control type for the ordered list block
package olid_pkg;

	localparam logic [1:0] OP_APPEND  = 2'd0;
	localparam logic [1:0] OP_PREPEND = 2'd1;
	localparam logic [1:0] OP_DELETE  = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 5;

	typedef struct packed {
		logic occupied;
		logic cmp_en;
		logic ld_val;
		logic ld_prev;
		logic ld_next;
	} olid_cell_ctrl_t;

endpackage

@@ hw/rtl/olid_cell.sv @@
// one entry cell of the list: holds a value, compares it, shifts to and from neighbors
module olid_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  olid_pkg::olid_cell_ctrl_t         ctrl,
	input  logic [olid_pkg::VALUE_W-1:0]      cmd_data,
	input  logic [olid_pkg::VALUE_W-1:0]      prev_data,
	input  logic [olid_pkg::VALUE_W-1:0]      next_data,
	output logic [olid_pkg::VALUE_W-1:0]      data,
	output logic                              match
);

	logic [olid_pkg::VALUE_W-1:0] data_q;
	logic                         match_s1;

	always_ff @(posedge clk) begin
		if (ctrl.ld_val) begin
			data_q <= cmd_data;
		end else if (ctrl.ld_prev) begin
			data_q <= prev_data;
		end else if (ctrl.ld_next) begin
			data_q <= next_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_s1 <= 1'b0;
		end else begin
			match_s1 <= ctrl.cmp_en & ctrl.occupied & (data_q == cmd_data);
		end
	end

	assign data  = data_q;
	assign match = match_s1;

endmodule

@@ hw/rtl/ordered_list_insert_delete.sv @@
// top level of the ordered list: command channel, row of entry cells, result channel
//
// Usage: each input word carries an operation (append at tail, prepend at head,
// delete first match) and a 32-bit signed value. Each command yields exactly one
// result word with a status (ok, not found, full) and the entry count after it.
// Steps: append, prepend and the unused code go straight to the output
// register; delete first runs the compare in every cell, then the first-match
// select and the shift that closes the gap.
// Throughput: one insert per cycle while in_stall is low; no command enters
// during a delete's apply step, which needs the registered cell match bits.
// Every cell shifts in parallel, so the time does not grow with DEPTH.
// A two-word result buffer (output register plus hold register) lets one more
// command enter while a result waits; with both full, in_stall stays high.
// Reset: asynchronous, clears the entry count and all valid flags; cell
// contents are left as they are and are never read before being written.
// When out_stall is high, the output word holds steady until taken.
module ordered_list_insert_delete #(
	parameter int unsigned DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [4:0]         entry_count
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [CW-1:0]                count_q;
	logic                         busy_q;
	logic                         out_valid_q;
	logic [1:0]                   out_status_q;
	logic [olid_pkg::COUNT_W-1:0] out_count_q;
	logic                         hold_valid_q;
	logic [1:0]                   hold_status_q;
	logic [olid_pkg::COUNT_W-1:0] hold_count_q;

	logic                             in_acc;
	logic                             full;
	logic                             is_ins;
	logic                             ins_ok;
	logic                             done;
	logic                             found;
	logic [1:0]                       res_status;
	logic [CW-1:0]                    count_d;
	logic [CW+olid_pkg::COUNT_W-1:0]  count_ext;
	logic                             out_free;
	logic [DEPTH-1:0]                 match;
	logic [DEPTH-1:0]                 match_dec;
	logic [DEPTH-1:0]                 low_mask;
	logic [DEPTH-1:0]                 first_hit;
	logic [DEPTH-1:0]                 shift_dn;
	logic [olid_pkg::VALUE_W-1:0]     cell_data [DEPTH];
	olid_pkg::olid_cell_ctrl_t        ctrl [DEPTH];

	assign in_stall = busy_q | hold_valid_q;
	assign in_acc   = in_valid & ~in_stall;
	assign full     = (count_q == DEPTH_C);
	assign is_ins   = (operation == olid_pkg::OP_APPEND) || (operation == olid_pkg::OP_PREPEND);
	assign ins_ok   = in_acc & is_ins & ~full;

	// first match select while a delete is being applied (busy_q)
	assign match_dec = match - DEPTH'(1);
	assign low_mask  = match ^ match_dec;
	assign first_hit = match & ~match_dec;
	assign shift_dn  = ~low_mask | first_hit;
	assign found     = |match;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			localparam logic [CW-1:0] IDX = CW'(gi);
			logic [olid_pkg::VALUE_W-1:0] prev_w;
			logic [olid_pkg::VALUE_W-1:0] next_w;

			if (gi == 0) begin : g_head
				assign prev_w = value;
			end else begin : g_mid
				assign prev_w = cell_data[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_tail
				assign next_w = cell_data[gi];
			end else begin : g_inner
				assign next_w = cell_data[gi+1];
			end

			always_comb begin
				ctrl[gi].occupied = (IDX < count_q);
				ctrl[gi].cmp_en   = in_acc && (operation == olid_pkg::OP_DELETE);
				ctrl[gi].ld_val   = ins_ok && (operation == olid_pkg::OP_APPEND) && (IDX == count_q);
				ctrl[gi].ld_prev  = ins_ok && (operation == olid_pkg::OP_PREPEND);
				ctrl[gi].ld_next  = busy_q && found && shift_dn[gi];
			end

			olid_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl[gi]),
				.cmd_data  (value),
				.prev_data (prev_w),
				.next_data (next_w),
				.data      (cell_data[gi]),
				.match     (match[gi])
			);
		end
	endgenerate

	// result of the command finishing this cycle
	always_comb begin
		done       = 1'b0;
		res_status = olid_pkg::ST_OK;
		count_d    = count_q;
		if (busy_q) begin
			done = 1'b1;
			if (found) begin
				count_d = count_q - CW'(1);
			end else begin
				res_status = olid_pkg::ST_NOT_FOUND;
			end
		end else if (in_acc) begin
			case (operation)
				olid_pkg::OP_APPEND, olid_pkg::OP_PREPEND: begin
					done = 1'b1;
					if (full) begin
						res_status = olid_pkg::ST_FULL;
					end else begin
						count_d = count_q + CW'(1);
					end
				end
				olid_pkg::OP_DELETE: begin
					done = 1'b0;
				end
				default: begin
					done = 1'b1;
				end
			endcase
		end
	end

	assign count_ext = {{olid_pkg::COUNT_W{1'b0}}, count_d};
	assign out_free  = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			busy_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			busy_q  <= in_acc && (operation == olid_pkg::OP_DELETE);
			if (out_free) begin
				if (hold_valid_q) begin
					out_valid_q  <= 1'b1;
					hold_valid_q <= done;
				end else begin
					out_valid_q <= done;
				end
			end else if (done) begin
				hold_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (hold_valid_q) begin
				out_status_q <= hold_status_q;
				out_count_q  <= hold_count_q;
				if (done) begin
					hold_status_q <= res_status;
					hold_count_q  <= count_ext[olid_pkg::COUNT_W-1:0];
				end
			end else if (done) begin
				out_status_q <= res_status;
				out_count_q  <= count_ext[olid_pkg::COUNT_W-1:0];
			end
		end else if (done) begin
			hold_status_q <= res_status;
			hold_count_q  <= count_ext[olid_pkg::COUNT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign entry_count = out_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above depth");

	a_hold_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q |-> out_valid_q)
		else $error("hold register full while output register empty");

	a_first_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(first_hit))
		else $error("more than one first match");

	a_delete_count: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && found) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("delete hit did not lower the count");

	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> !busy_q)
		else $error("delete apply lasted more than one cycle");

endmodule
